[rtl/core/sktbl_pkg.sv]
// Shared operation codes, status codes and result type of the sorted key table.
`default_nettype none

package sktbl_pkg;

  // Operation codes carried on the input transaction
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Status codes carried on the output transaction
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_ABSENT   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_READ_OK  = 3'd5;
  localparam logic [2:0] ST_RANGE    = 3'd6;

  // One finished result, handed from the sequencer to the output register
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entry_count;
    logic [15:0] entry_key;
    logic [31:0] entry_payload;
    logic        first_greater;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/sktbl_mem.sv]
// Single write port, single registered read port entry memory of the table.
`default_nettype none

module sktbl_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/sktbl_seq.sv]
// Sequencer: search, shift and read over the entry memory, plus count and head key.
`default_nettype none

module sktbl_seq #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int EW = KEY_BITS + 32
) (
  input  wire                  clk,
  input  wire                  rst,
  // input transaction
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [1:0]            operation,
  input  wire [15:0]           key,
  input  wire [31:0]           payload,
  input  wire [3:0]            index,
  // finished result
  output logic                 res_valid,
  input  wire                  res_take,
  output sktbl_pkg::result_t   res,
  // memory port
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [EW-1:0]        mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  wire [EW-1:0]         mem_rdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_ACT      = 3'd2;
  localparam logic [2:0] S_SHIFT_UP = 3'd3;
  localparam logic [2:0] S_PLACE    = 3'd4;
  localparam logic [2:0] S_SHIFT_DN = 3'd5;
  localparam logic [2:0] S_RDATA    = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  logic [2:0]          state, state_next;
  logic [1:0]          op_r, op_r_next;
  logic [KEY_BITS-1:0] key_r, key_r_next;
  logic [31:0]         pl_r, pl_r_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       pos, pos_next;
  logic [CW-1:0]       j, j_next;
  logic                found, found_next;
  logic [KEY_BITS-1:0] head_key, head_key_next;
  logic [2:0]          status_r, status_r_next;
  logic [KEY_BITS-1:0] rkey_r, rkey_r_next;
  logic [31:0]         rpay_r, rpay_r_next;

  logic [KEY_BITS-1:0] key_in;
  logic [KEY_BITS-1:0] rd_key;
  logic [31:0]         rd_pay;
  logic [CW-1:0]       pos_inc;
  logic                scan_on;
  logic                idx_ok;

  assign key_in  = KEY_BITS'(key);
  assign rd_key  = mem_rdata[EW-1:32];
  assign rd_pay  = mem_rdata[31:0];
  assign pos_inc = CW'(pos + CW'(1));
  assign idx_ok  = ({28'd0, index} < 32'(count)) && ({28'd0, index} < 32'(TABLE_DEPTH));

  // Keep scanning while the stored key sorts ahead of (insert) or differs from (remove) the key
  assign scan_on = (op_r == sktbl_pkg::OP_INSERT) ? (rd_key > key_r) : (rd_key != key_r);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // Present the result from the updated state
  always_comb begin
    res.status        = status_r;
    res.entry_count   = 5'(count);
    res.entry_key     = 16'(rkey_r);
    res.entry_payload = rpay_r;
    res.first_greater = (count != '0) && (head_key > key_r);
  end

  // Next state and memory requests
  always_comb begin
    state_next    = state;
    op_r_next     = op_r;
    key_r_next    = key_r;
    pl_r_next     = pl_r;
    count_next    = count;
    pos_next      = pos;
    j_next        = j;
    found_next    = found;
    head_key_next = head_key;
    status_r_next = status_r;
    rkey_r_next   = rkey_r;
    rpay_r_next   = rpay_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(pos);
    mem_wdata     = {key_r, pl_r};
    mem_re        = 1'b0;
    mem_raddr     = '0;

    case (state)
      // Latch the transaction and start the search or the read, or flag an out-of-range index
      S_IDLE: begin
        if (in_valid) begin
          op_r_next   = operation;
          key_r_next  = key_in;
          pl_r_next   = payload;
          pos_next    = '0;
          rkey_r_next = '0;
          rpay_r_next = '0;
          if (operation == sktbl_pkg::OP_INSERT || operation == sktbl_pkg::OP_REMOVE) begin
            if (count == '0) begin
              found_next = 1'b0;
              state_next = S_ACT;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = '0;
              state_next = S_SCAN;
            end
          end else if (idx_ok) begin
            mem_re     = 1'b1;
            mem_raddr  = AW'(index);
            state_next = S_RDATA;
          end else begin
            status_r_next = sktbl_pkg::ST_RANGE;
            state_next    = S_DONE;
          end
        end
      end

      // Walk the table one entry per cycle
      S_SCAN: begin
        if (scan_on) begin
          pos_next = pos_inc;
          if (pos_inc == count) begin
            found_next = 1'b0;
            state_next = S_ACT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pos_inc);
          end
        end else begin
          found_next = (rd_key == key_r);
          state_next = S_ACT;
        end
      end

      // Decide the outcome and start any shift
      S_ACT: begin
        if (op_r == sktbl_pkg::OP_INSERT) begin
          if (found) begin
            mem_we        = 1'b1;
            status_r_next = sktbl_pkg::ST_REPLACED;
            state_next    = S_DONE;
          end else if (count == FULL_COUNT) begin
            status_r_next = sktbl_pkg::ST_FULL;
            state_next    = S_DONE;
          end else if (pos == count) begin
            mem_we        = 1'b1;
            if (pos == '0) begin
              head_key_next = key_r;
            end
            count_next    = CW'(count + CW'(1));
            status_r_next = sktbl_pkg::ST_INSERTED;
            state_next    = S_DONE;
          end else begin
            j_next     = count;
            mem_re     = 1'b1;
            mem_raddr  = AW'(count - CW'(1));
            state_next = S_SHIFT_UP;
          end
        end else begin
          if (!found) begin
            status_r_next = sktbl_pkg::ST_ABSENT;
            state_next    = S_DONE;
          end else if (pos_inc == count) begin
            count_next    = CW'(count - CW'(1));
            status_r_next = sktbl_pkg::ST_REMOVED;
            state_next    = S_DONE;
          end else begin
            j_next     = pos;
            mem_re     = 1'b1;
            mem_raddr  = AW'(pos_inc);
            state_next = S_SHIFT_DN;
          end
        end
      end

      // Move entry j-1 up to j, reading the next one ahead
      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j);
        mem_wdata = mem_rdata;
        if (CW'(j - CW'(1)) == pos) begin
          state_next = S_PLACE;
        end else begin
          j_next    = CW'(j - CW'(1));
          mem_re    = 1'b1;
          mem_raddr = AW'(j - CW'(2));
        end
      end

      // Drop the new entry into the opened slot
      S_PLACE: begin
        mem_we = 1'b1;
        if (pos == '0) begin
          head_key_next = key_r;
        end
        count_next    = CW'(count + CW'(1));
        status_r_next = sktbl_pkg::ST_INSERTED;
        state_next    = S_DONE;
      end

      // Move entry j+1 down to j to close the gap
      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j);
        mem_wdata = mem_rdata;
        if (j == '0) begin
          head_key_next = rd_key;
        end
        if (CW'(j + CW'(2)) == count) begin
          count_next    = CW'(count - CW'(1));
          status_r_next = sktbl_pkg::ST_REMOVED;
          state_next    = S_DONE;
        end else begin
          j_next    = CW'(j + CW'(1));
          mem_re    = 1'b1;
          mem_raddr = AW'(j + CW'(2));
        end
      end

      // Capture the entry that was read
      S_RDATA: begin
        rkey_r_next   = rd_key;
        rpay_r_next   = rd_pay;
        status_r_next = sktbl_pkg::ST_READ_OK;
        state_next    = S_DONE;
      end

      // Hold the result until the output register takes it
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    key_r    <= key_r_next;
    pl_r     <= pl_r_next;
    pos      <= pos_next;
    j        <= j_next;
    found    <= found_next;
    head_key <= head_key_next;
    status_r <= status_r_next;
    rkey_r   <= rkey_r_next;
    rpay_r   <= rpay_r_next;
  end

`ifndef SYNTH
  a_no_addr_clash: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write of the same entry in one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (count == $past(count)) || (count == CW'($past(count) + CW'(1)))
             || (CW'(count + CW'(1)) == $past(count)))
    else $error("entry count moved by more than one");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_ACT) || (state == S_SHIFT_UP) || (state == S_PLACE)
               || (state == S_SHIFT_DN))
    else $error("memory write outside an update step");
`endif

endmodule

`default_nettype wire

[rtl/core/sorted_key_table_core.sv]
// Top level of the sorted key table: sequencer, entry memory and output register.
//
// The table holds up to TABLE_DEPTH entries (key and payload) with unique keys in
// descending key order. Each input transaction (operation, key, payload, index) on
// the in_valid/in_ready channel gives exactly one output transaction (status,
// entry_count, entry_key, entry_payload, first_greater) on out_valid/out_ready.
// Items are worked one at a time; in_ready is high while the sequencer is idle.
// An out-of-range read goes straight to its result; a read first captures the
// entry; an insert or remove searches the stored entries, decides, shifts if
// needed and, for an insert that shifts, places the new entry before its result.
// The search reads one entry per cycle and the shift moves one entry per cycle,
// both through the single read and single write port of the entry memory.
// The output register frees the sequencer when it loads, so the next transaction
// is accepted while a result waits; a stalled receiver holds one result and then
// stops the sequencer, which in turn holds in_ready low.
// Reset clears the entry count and the control state; memory
// contents are not cleared, since only entries below the count are ever read.
`default_nettype none

module sorted_key_table_core #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  operation,
  input  wire  [15:0] key,
  input  wire  [31:0] payload,
  input  wire  [3:0]  index,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  status,
  output logic [4:0]  entry_count,
  output logic [15:0] entry_key,
  output logic [31:0] entry_payload,
  output logic        first_greater
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = KEY_BITS + 32;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [EW-1:0]      mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [EW-1:0]      mem_rdata;
  logic               res_valid;
  logic               res_take;
  sktbl_pkg::result_t res;
  sktbl_pkg::result_t out_r;

  sktbl_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .key       (key),
    .payload   (payload),
    .index     (index),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sktbl_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Load the output register when it is empty or being emptied
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign status        = out_r.status;
  assign entry_count   = out_r.entry_count;
  assign entry_key     = out_r.entry_key;
  assign entry_payload = out_r.entry_payload;
  assign first_greater = out_r.first_greater;

endmodule

`default_nettype wire
